// ===== hw/rtl/skd_pkg.sv =====
// Shared types, constants and helper functions of the SimCC keypoint decoder.
`default_nettype none

package skd_pkg;

  localparam int X_BINS     = 576;
  localparam int Y_BINS     = 768;
  localparam int SCORE_BITS = 16;

  localparam int KP_W       = 5;
  localparam int AXIS_W     = 2;
  localparam int BIN_W      = 10;
  localparam int CROP_W     = 16;
  localparam int FRAME_W    = 13;
  localparam int IMG_W      = 17;
  localparam int POS_W      = 10;
  localparam int CONF_W     = 15;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int IN_DATA_W  = ((KP_W + BIN_W + SCORE_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = KP_W + 2 * IMG_W + 3 * POS_W + CONF_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [AXIS_W-1:0] AXIS_X = AXIS_W'(0);
  localparam logic [AXIS_W-1:0] AXIS_Y = AXIS_W'(1);
  localparam logic [AXIS_W-1:0] AXIS_Z = AXIS_W'(2);

  localparam logic [CFG_ADDR_W-1:0] CFG_CROP_LEFT    = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_CROP_TOP     = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] CFG_CROP_WIDTH   = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] CFG_CROP_HEIGHT  = CFG_ADDR_W'(3);
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH  = CFG_ADDR_W'(4);
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT = CFG_ADDR_W'(5);

  localparam logic [CROP_W-1:0]  RST_CROP_LEFT    = CROP_W'(0);
  localparam logic [CROP_W-1:0]  RST_CROP_TOP     = CROP_W'(0);
  localparam logic [CROP_W-1:0]  RST_CROP_WIDTH   = CROP_W'(4608);
  localparam logic [CROP_W-1:0]  RST_CROP_HEIGHT  = CROP_W'(6144);
  localparam logic [FRAME_W-1:0] RST_FRAME_WIDTH  = FRAME_W'(1920);
  localparam logic [FRAME_W-1:0] RST_FRAME_HEIGHT = FRAME_W'(1080);

  // Scaling: n = bin * size + bins / 2, then n / bins by reciprocal multiplication.
  localparam int PROD_W    = BIN_W + CROP_W + 1;
  localparam int RECIP_W   = PROD_W + 1;
  localparam int IMG_SUM_W = PROD_W + 1;
  localparam int X_SHIFT   = PROD_W + $clog2(X_BINS);
  localparam int Y_SHIFT   = PROD_W + $clog2(Y_BINS);
  localparam logic [63:0] X_RECIP64 =
    ((64'd1 << X_SHIFT) + 64'(X_BINS) - 64'd1) / 64'(X_BINS);
  localparam logic [63:0] Y_RECIP64 =
    ((64'd1 << Y_SHIFT) + 64'(Y_BINS) - 64'd1) / 64'(Y_BINS);
  localparam logic [RECIP_W-1:0] X_RECIP = X_RECIP64[RECIP_W-1:0];
  localparam logic [RECIP_W-1:0] Y_RECIP = Y_RECIP64[RECIP_W-1:0];
  localparam logic [PROD_W-1:0]  X_HALF  = PROD_W'(X_BINS / 2);
  localparam logic [PROD_W-1:0]  Y_HALF  = PROD_W'(Y_BINS / 2);

  localparam int POS_CALC_W = BIN_W + 2;
  localparam logic signed [POS_CALC_W-1:0] X_MID  = POS_CALC_W'(X_BINS / 2);
  localparam logic signed [POS_CALC_W-1:0] Y_MID  = POS_CALC_W'(Y_BINS / 2);
  localparam logic signed [POS_CALC_W-1:0] POS_LO = POS_CALC_W'(-(2 ** (POS_W - 1)));
  localparam logic signed [POS_CALC_W-1:0] POS_HI = POS_CALC_W'((2 ** (POS_W - 1)) - 1);

  localparam logic [IMG_SUM_W-1:0] IMG_MAX = IMG_SUM_W'((2 ** IMG_W) - 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [KP_W-1:0]              kp;
    logic [BIN_W-1:0]             bin_x;
    logic [BIN_W-1:0]             bin_y;
    logic [BIN_W-1:0]             bin_z;
    logic signed [SCORE_BITS-1:0] score_x;
    logic signed [SCORE_BITS-1:0] score_y;
    logic signed [SCORE_BITS-1:0] score_z;
  } skd_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } skd_qstat_t;

  typedef struct packed {
    logic [CROP_W-1:0]  crop_left;
    logic [CROP_W-1:0]  crop_top;
    logic [CROP_W-1:0]  crop_width;
    logic [CROP_W-1:0]  crop_height;
    logic [FRAME_W-1:0] frame_width;
    logic [FRAME_W-1:0] frame_height;
  } skd_cfg_t;

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [POS_CALC_W-1:0] v);
    logic [POS_W-1:0] r;
    if (v < POS_LO) begin
      r = POS_LO[POS_W-1:0];
    end else if (v > POS_HI) begin
      r = POS_HI[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/skd_front.sv =====
// Front end: takes score items and keeps the running peak of each axis.
`default_nettype none

module skd_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [skd_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic [skd_pkg::AXIS_W-1:0]   in_tuser,
  input  wire logic                         in_tlast,
  input  wire skd_pkg::skd_qstat_t          q_stat,
  output logic                              push,
  output skd_pkg::skd_rec_t                 push_rec
);
  import skd_pkg::*;

  localparam int BIN_LO   = KP_W;
  localparam int SCORE_LO = KP_W + BIN_W;

  logic signed [SCORE_BITS-1:0] peak_score_r   [3];
  logic signed [SCORE_BITS-1:0] peak_score_nxt [3];
  logic [BIN_W-1:0]             peak_bin_r     [3];
  logic [BIN_W-1:0]             peak_bin_nxt   [3];
  logic [2:0]                   run_open_r;
  logic [2:0]                   run_open_nxt;

  logic                         accept;
  logic [KP_W-1:0]              kp;
  logic [BIN_W-1:0]             bin;
  logic signed [SCORE_BITS-1:0] score;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign kp        = in_tdata[KP_W-1:0];
  assign bin       = in_tdata[BIN_LO +: BIN_W];
  assign score     = in_tdata[SCORE_LO +: SCORE_BITS];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      peak_score_nxt[a] = peak_score_r[a];
      peak_bin_nxt[a]   = peak_bin_r[a];
      run_open_nxt[a]   = run_open_r[a];
      if (accept && in_tuser == AXIS_W'(a)) begin
        if (!run_open_r[a] || score > peak_score_r[a]) begin
          peak_score_nxt[a] = score;
          peak_bin_nxt[a]   = bin;
        end
        run_open_nxt[a] = !in_tlast;
      end
    end
  end

  assign push             = accept && in_tuser == AXIS_Z && in_tlast;
  assign push_rec.kp      = kp;
  assign push_rec.bin_x   = peak_bin_nxt[0];
  assign push_rec.bin_y   = peak_bin_nxt[1];
  assign push_rec.bin_z   = peak_bin_nxt[2];
  assign push_rec.score_x = peak_score_nxt[0];
  assign push_rec.score_y = peak_score_nxt[1];
  assign push_rec.score_z = peak_score_nxt[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        peak_score_r[a] <= {1'b1, {(SCORE_BITS - 1){1'b0}}};
        peak_bin_r[a]   <= '0;
      end
      run_open_r <= '0;
    end else begin
      for (int a = 0; a < 3; a++) begin
        peak_score_r[a] <= peak_score_nxt[a];
        peak_bin_r[a]   <= peak_bin_nxt[a];
      end
      run_open_r <= run_open_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/skd_queue.sv =====
// Short queue of finished peak records between the front end and the back end.
`default_nettype none

module skd_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire skd_pkg::skd_rec_t push_rec,
  input  wire logic              pop,
  output skd_pkg::skd_rec_t      head,
  output skd_pkg::skd_qstat_t    q_stat
);
  import skd_pkg::*;

  skd_rec_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.full  = count_r == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign q_stat.empty = count_r == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/skd_back.sv =====
// Back end: maps peak bins into the frame and forms the result item.
`default_nettype none

module skd_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire skd_pkg::skd_cfg_t              cfg,
  input  wire logic                           rec_valid,
  input  wire skd_pkg::skd_rec_t              rec,
  output logic                                pop,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [skd_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tuser
);
  import skd_pkg::*;

  logic en;

  // Stage 1: bin times crop size plus half the bin count, confidence and 3D position.
  logic                         s1_valid_r;
  logic [KP_W-1:0]              s1_kp_r;
  logic [PROD_W-1:0]            s1_nx_r, s1_ny_r;
  logic [PROD_W-1:0]            s1_nx_nxt, s1_ny_nxt;
  logic [POS_W-1:0]             s1_px_r, s1_py_r, s1_pz_r;
  logic [CONF_W-1:0]            s1_conf_r, s1_conf_nxt;
  logic signed [SCORE_BITS-1:0] min_xy, min_xyz;

  // Stage 2: division by the bin count through the reciprocal.
  logic                         s2_valid_r;
  logic [KP_W-1:0]              s2_kp_r;
  logic [PROD_W-1:0]            s2_qx_r, s2_qy_r;
  logic [PROD_W+RECIP_W-1:0]    mx, my;
  logic [POS_W-1:0]             s2_px_r, s2_py_r, s2_pz_r;
  logic [CONF_W-1:0]            s2_conf_r;

  // Stage 3: origin added, bounds test, saturation; this is the output register.
  logic                         s3_valid_r;
  logic [KP_W-1:0]              s3_kp_r;
  logic [IMG_W-1:0]             s3_ix_r, s3_iy_r, s3_ix_nxt, s3_iy_nxt;
  logic [POS_W-1:0]             s3_px_r, s3_py_r, s3_pz_r;
  logic [CONF_W-1:0]            s3_conf_r;
  logic                         s3_ok_r, s3_ok_nxt;
  logic [IMG_SUM_W-1:0]         sum_x, sum_y;

  assign en  = !s3_valid_r || out_tready;
  assign pop = en && rec_valid;

  always_comb begin
    s1_nx_nxt = PROD_W'(rec.bin_x) * PROD_W'(cfg.crop_width) + X_HALF;
    s1_ny_nxt = PROD_W'(rec.bin_y) * PROD_W'(cfg.crop_height) + Y_HALF;
    min_xy    = (rec.score_y < rec.score_x) ? rec.score_y : rec.score_x;
    min_xyz   = (rec.score_z < min_xy) ? rec.score_z : min_xy;
    if (min_xyz[SCORE_BITS-1]) begin
      s1_conf_nxt = '0;
    end else begin
      s1_conf_nxt = CONF_W'(unsigned'(min_xyz));
    end
  end

  assign mx = (PROD_W + RECIP_W)'(s1_nx_r) * (PROD_W + RECIP_W)'(X_RECIP);
  assign my = (PROD_W + RECIP_W)'(s1_ny_r) * (PROD_W + RECIP_W)'(Y_RECIP);

  always_comb begin
    sum_x     = IMG_SUM_W'(cfg.crop_left) + IMG_SUM_W'(s2_qx_r);
    sum_y     = IMG_SUM_W'(cfg.crop_top) + IMG_SUM_W'(s2_qy_r);
    s3_ix_nxt = (sum_x > IMG_MAX) ? IMG_MAX[IMG_W-1:0] : sum_x[IMG_W-1:0];
    s3_iy_nxt = (sum_y > IMG_MAX) ? IMG_MAX[IMG_W-1:0] : sum_y[IMG_W-1:0];
    s3_ok_nxt = (sum_x <= IMG_SUM_W'({cfg.frame_width, 4'b0000})) &&
                (sum_y <= IMG_SUM_W'({cfg.frame_height, 4'b0000}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kp_r   <= rec.kp;
      s1_nx_r   <= s1_nx_nxt;
      s1_ny_r   <= s1_ny_nxt;
      s1_conf_r <= s1_conf_nxt;
      s1_px_r   <= sat_pos(POS_CALC_W'(rec.bin_x) - X_MID);
      s1_py_r   <= sat_pos(Y_MID - POS_CALC_W'(rec.bin_y));
      s1_pz_r   <= sat_pos(POS_CALC_W'(rec.bin_z) - X_MID);

      s2_kp_r   <= s1_kp_r;
      s2_qx_r   <= PROD_W'(mx >> X_SHIFT);
      s2_qy_r   <= PROD_W'(my >> Y_SHIFT);
      s2_px_r   <= s1_px_r;
      s2_py_r   <= s1_py_r;
      s2_pz_r   <= s1_pz_r;
      s2_conf_r <= s1_conf_r;

      s3_kp_r   <= s2_kp_r;
      s3_ix_r   <= s3_ix_nxt;
      s3_iy_r   <= s3_iy_nxt;
      s3_ok_r   <= s3_ok_nxt;
      s3_px_r   <= s2_px_r;
      s3_py_r   <= s2_py_r;
      s3_pz_r   <= s2_pz_r;
      s3_conf_r <= s2_conf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= rec_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  assign out_tvalid = s3_valid_r;
  assign out_tuser  = s3_ok_r;
  assign out_tdata  = OUT_DATA_W'({s3_conf_r, s3_pz_r, s3_py_r, s3_px_r,
                                   s3_iy_r, s3_ix_r, s3_kp_r});

endmodule

`default_nettype wire

// ===== hw/rtl/simcc_keypoint_decoder_top.sv =====
// Top level of the SimCC keypoint decoder: configuration registers and the three parts.
// Throughput: one score item per cycle; in_tready falls only when the four-entry record
// queue is full, which needs the result side to stall.
// A result is shown once the last z item of a keypoint has passed the record queue and
// the multiply-add, reciprocal-multiply and output stages of the back end.
// Reset: synchronous, active low; peaks, queue and pipeline are cleared at once.
`default_nettype none

module simcc_keypoint_decoder_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // keypoint [4:0], bin [14:5], score [30:15], zero [31]
  input  wire logic [skd_pkg::IN_DATA_W-1:0]    in_tdata,
  // axis [1:0]
  input  wire logic [skd_pkg::AXIS_W-1:0]       in_tuser,
  input  wire logic                             in_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // point_index [4:0], image_x [21:5], image_y [38:22], pos_x [48:39],
  // pos_y [58:49], pos_z [68:59], confidence [83:69], zero [87:84]
  output logic [skd_pkg::OUT_DATA_W-1:0]        out_tdata,
  // valid_res [0]
  output logic                                  out_tuser,
  input  wire logic                             cfg_we,
  input  wire logic [skd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [skd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import skd_pkg::*;

  skd_cfg_t   cfg_r;
  skd_qstat_t q_stat;
  skd_rec_t   push_rec;
  skd_rec_t   head;
  logic       push;
  logic       q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crop_left    <= RST_CROP_LEFT;
      cfg_r.crop_top     <= RST_CROP_TOP;
      cfg_r.crop_width   <= RST_CROP_WIDTH;
      cfg_r.crop_height  <= RST_CROP_HEIGHT;
      cfg_r.frame_width  <= RST_FRAME_WIDTH;
      cfg_r.frame_height <= RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CROP_LEFT:    cfg_r.crop_left    <= cfg_wdata[CROP_W-1:0];
        CFG_CROP_TOP:     cfg_r.crop_top     <= cfg_wdata[CROP_W-1:0];
        CFG_CROP_WIDTH:   cfg_r.crop_width   <= cfg_wdata[CROP_W-1:0];
        CFG_CROP_HEIGHT:  cfg_r.crop_height  <= cfg_wdata[CROP_W-1:0];
        CFG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_wdata[FRAME_W-1:0];
        CFG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_wdata[FRAME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  skd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_rec  (push_rec)
  );

  skd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  skd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .rec_valid  (!q_stat.empty),
    .rec        (head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("Record taken from an empty queue.");

  a_valid_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (out_tdata[21:5] <= {cfg_r.frame_width, 4'b0000}))
    else $error("Result flagged valid with image_x outside the frame.");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Result shown straight after reset.");
`endif

endmodule

`default_nettype wire
